FILE: sv/gpsc_pkg.sv
// Shared types and constants for the gamepad sample conditioner.
`default_nettype none

package gpsc_pkg;

  localparam int unsigned ADC_W     = 10;
  localparam int unsigned BTN_W     = 32;
  localparam int unsigned SEQ_W     = 16;
  localparam int unsigned RUN_W     = 8;
  localparam int unsigned ALPHA_W   = 9;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 104;

  localparam logic [ADC_W-1:0]   ADC_MAX   = 10'd1023;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
  localparam logic [RUN_W-1:0]   RUN_MAX   = 8'd255;

  typedef enum logic [2:0] {
    STAT_ACCEPTED = 3'd0,
    STAT_READ_ERR = 3'd1,
    STAT_INVALID  = 3'd2,
    STAT_WARN     = 3'd3,
    STAT_DISABLE  = 3'd4
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_MASK   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q8      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_LIMIT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_LEVEL    = 8'd3;

  // Result of one axis filter update
  typedef struct packed {
    logic [ADC_W-1:0] value;
    logic             moved;
  } axis_res_t;

endpackage

`default_nettype wire

FILE: sv/gpsc_ewma.sv
// Q8 exponential smoothing of one joystick axis with movement detect.
`default_nettype none

module gpsc_ewma (
  input  wire logic [gpsc_pkg::ALPHA_W-1:0] alpha_i,
  input  wire logic                         primed_i,
  input  wire logic [gpsc_pkg::ADC_W-1:0]   fresh_i,
  input  wire logic [gpsc_pkg::ADC_W-1:0]   old_i,
  output gpsc_pkg::axis_res_t               res_o
);

  logic        [gpsc_pkg::ALPHA_W-1:0] a_sat;
  logic signed [gpsc_pkg::ADC_W:0]     diff;
  logic signed [20:0]                  prod;
  logic signed [21:0]                  acc;
  logic        [gpsc_pkg::ADC_W-1:0]   filt;
  logic signed [gpsc_pkg::ADC_W:0]     delta;

  always_comb begin
    a_sat = alpha_i[gpsc_pkg::ALPHA_W-1] ? gpsc_pkg::ALPHA_ONE : alpha_i;
    diff  = $signed({1'b0, fresh_i}) - $signed({1'b0, old_i});
    prod  = $signed({1'b0, a_sat}) * diff;
    // old*256 + a*(new-old) + 128 equals a*new + (256-a)*old + 128
    acc   = $signed({4'b0, old_i, 8'b0}) + 22'(prod) + 22'sd128;
    filt  = primed_i ? acc[17:8] : fresh_i;
    delta = $signed({1'b0, old_i}) - $signed({1'b0, filt});
    res_o.value = filt;
    res_o.moved = (delta > 11'sd1) || (delta < -11'sd1);
  end

endmodule

`default_nettype wire

FILE: sv/gamepad_sample_conditioner.sv
// Top level of the gamepad sample conditioner: debounce, axis filter, status.
//
// One input item on the s_axis group is one poll sample; every sample gives
// exactly one result item on the m_axis group. Samples pass an input register,
// combinational conditioning logic, and a result register. A result is
// presented when its sample moves into the result register, which waits while
// an earlier result is held there. Throughput is one item per cycle while the
// receiver takes results: the input register is refilled in the cycle its item
// moves to the result register, so a result waiting on the receiver stops the
// next sample only once the input register is full as well. When the receiver
// holds m_axis_tready low, the result register holds, the input register fills,
// and then s_axis_tready falls until the result leaves. Reset loads the
// register defaults (mask 0x00010067, alpha 179, invalid limit 20, warning
// level 10), marks both registers empty, sets the accepted and pending button
// words to all ones and clears the filter, press, sequence and invalid-run
// state. The user writes configuration through cfg_we_i/cfg_idx_i/cfg_data_i
// only while no item is in flight (not enforced); unknown indexes are ignored.
`default_nettype none

module gamepad_sample_conditioner (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // read_ok, raw_buttons[31:0], edge_flags[31:0], adc_x[9:0], adc_y[9:0],
  // clear_presses, two zero pad bits
  input  wire logic [gpsc_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  input  wire logic                                s_axis_tvalid_i,
  output      logic                                s_axis_tready_o,
  // status[2:0], stable_buttons[31:0], joy_x[9:0], joy_y[9:0],
  // press_accum[31:0], change_seq[15:0], data_valid
  output      logic [gpsc_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  output      logic                                m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [gpsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [gpsc_pkg::CFG_DAT_W-1:0]      cfg_data_i
);

  localparam int unsigned BW = gpsc_pkg::BTN_W;
  localparam int unsigned AW = gpsc_pkg::ADC_W;

  // Configuration registers
  logic [BW-1:0]                     button_mask_q;
  logic [gpsc_pkg::ALPHA_W-1:0]      alpha_q;
  logic [gpsc_pkg::RUN_W-1:0]        invalid_limit_q;
  logic [gpsc_pkg::RUN_W-1:0]        warn_level_q;

  // Handshake and payload registers
  logic                              in_valid_q, in_valid_d;
  logic [gpsc_pkg::IN_DATA_W-1:0]    in_data_q;
  logic                              out_valid_q, out_valid_d;
  logic [gpsc_pkg::OUT_DATA_W-1:0]   out_data_q, out_data_d;
  logic                              advance;

  // Conditioning state
  logic [BW-1:0]                     accepted_q, accepted_d;
  logic [BW-1:0]                     pending_q, pending_d;
  logic [1:0]                        pend_cnt_q, pend_cnt_d;
  logic [BW-1:0]                     reported_q, reported_d;
  logic [AW-1:0]                     smooth_x_q, smooth_x_d;
  logic [AW-1:0]                     smooth_y_q, smooth_y_d;
  logic                              primed_q, primed_d;
  logic [BW-1:0]                     press_q, press_d;
  logic [gpsc_pkg::SEQ_W-1:0]        seq_q, seq_d;
  logic [gpsc_pkg::RUN_W-1:0]        run_q, run_d;
  logic                              seen_q, seen_d;

  // Fields of the held sample
  logic                              f_read_ok;
  logic [BW-1:0]                     f_raw;
  logic [BW-1:0]                     f_edge;
  logic [AW-1:0]                     f_adc_x;
  logic [AW-1:0]                     f_adc_y;
  logic                              f_clear;

  logic [AW-1:0]                     inv_x, inv_y;
  logic                              sample_bad;
  logic [BW-1:0]                     now_btn;
  logic [BW-1:0]                     pressed;
  logic [BW-1:0]                     press_out;
  logic [gpsc_pkg::RUN_W-1:0]        run_inc;
  gpsc_pkg::status_e                 status;
  gpsc_pkg::axis_res_t               res_x, res_y;

  assign f_read_ok = in_data_q[0];
  assign f_raw     = in_data_q[32:1];
  assign f_edge    = in_data_q[64:33] & button_mask_q;
  assign f_adc_x   = in_data_q[74:65];
  assign f_adc_y   = in_data_q[84:75];
  assign f_clear   = in_data_q[85];

  assign inv_x = gpsc_pkg::ADC_MAX - f_adc_x;
  assign inv_y = gpsc_pkg::ADC_MAX - f_adc_y;

  gpsc_ewma u_ewma_x (
    .alpha_i  (alpha_q),
    .primed_i (primed_q),
    .fresh_i  (inv_x),
    .old_i    (smooth_x_q),
    .res_o    (res_x)
  );

  gpsc_ewma u_ewma_y (
    .alpha_i  (alpha_q),
    .primed_i (primed_q),
    .fresh_i  (inv_y),
    .old_i    (smooth_y_q),
    .res_o    (res_y)
  );

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_valid_d      = (s_axis_tvalid_i && s_axis_tready_o) || (in_valid_q && !advance);
  assign out_valid_d     = advance || (out_valid_q && !m_axis_tready_i);

  always_comb begin
    accepted_d = accepted_q;
    pending_d  = pending_q;
    pend_cnt_d = pend_cnt_q;
    reported_d = reported_q;
    smooth_x_d = smooth_x_q;
    smooth_y_d = smooth_y_q;
    primed_d   = primed_q;
    seq_d      = seq_q;
    run_d      = run_q;
    seen_d     = seen_q;
    now_btn    = f_raw;
    pressed    = '0;
    status     = gpsc_pkg::STAT_ACCEPTED;
    sample_bad = ((f_raw & ~button_mask_q) != '0) || ((f_raw & button_mask_q) == '0);
    run_inc    = (run_q == gpsc_pkg::RUN_MAX) ? run_q : run_q + 1'b1;

    if (!f_read_ok) begin
      status = gpsc_pkg::STAT_READ_ERR;
    end else if (sample_bad) begin
      run_d = run_inc;
      if (run_inc >= invalid_limit_q) begin
        status = gpsc_pkg::STAT_DISABLE;
      end else if (run_inc >= warn_level_q) begin
        status = gpsc_pkg::STAT_WARN;
      end else begin
        status = gpsc_pkg::STAT_INVALID;
      end
    end else begin
      run_d = '0;
      if (f_raw != accepted_q) begin
        if (f_raw == pending_q) begin
          pend_cnt_d = (pend_cnt_q == 2'd3) ? pend_cnt_q : pend_cnt_q + 2'd1;
        end else begin
          pending_d  = f_raw;
          pend_cnt_d = 2'd1;
        end
        if (pend_cnt_d < 2'd2) begin
          now_btn = accepted_q;
        end
      end else begin
        pending_d  = f_raw;
        pend_cnt_d = 2'd0;
      end
      accepted_d = now_btn;
      primed_d   = 1'b1;
      smooth_x_d = res_x.value;
      smooth_y_d = res_y.value;
      pressed    = (reported_q & ~now_btn) | (f_edge & (~now_btn | accepted_q));
      reported_d = now_btn;
      seen_d     = 1'b1;
      if ((reported_q != now_btn) || res_x.moved || res_y.moved) begin
        seq_d = seq_q + 1'b1;
      end
    end

    press_out = press_q | pressed;
    press_d   = f_clear ? '0 : press_out;
    out_data_d = {seen_d, seq_d, press_out, smooth_y_d, smooth_x_d, reported_d, status};
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_mask_q   <= 32'h0001_0067;
      alpha_q         <= 9'd179;
      invalid_limit_q <= 8'd20;
      warn_level_q    <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gpsc_pkg::CFG_BUTTON_MASK:   button_mask_q   <= cfg_data_i;
        gpsc_pkg::CFG_ALPHA_Q8:      alpha_q         <= cfg_data_i[gpsc_pkg::ALPHA_W-1:0];
        gpsc_pkg::CFG_INVALID_LIMIT: invalid_limit_q <= cfg_data_i[gpsc_pkg::RUN_W-1:0];
        gpsc_pkg::CFG_WARN_LEVEL:    warn_level_q    <= cfg_data_i[gpsc_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepted_q <= '1;
      pending_q  <= '1;
      pend_cnt_q <= '0;
      reported_q <= '0;
      smooth_x_q <= '0;
      smooth_y_q <= '0;
      primed_q   <= 1'b0;
      press_q    <= '0;
      seq_q      <= '0;
      run_q      <= '0;
      seen_q     <= 1'b0;
    end else if (advance) begin
      accepted_q <= accepted_d;
      pending_q  <= pending_d;
      pend_cnt_q <= pend_cnt_d;
      reported_q <= reported_d;
      smooth_x_q <= smooth_x_d;
      smooth_y_q <= smooth_y_d;
      primed_q   <= primed_d;
      press_q    <= press_d;
      seq_q      <= seq_d;
      run_q      <= run_d;
      seen_q     <= seen_d;
    end
  end

`ifndef SYNTHESIS
  a_ready_low_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && out_valid_q && !m_axis_tready_i)
    else $error("input side stalled without a held item and a stalled result");

  a_accepted_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[2:0] == gpsc_pkg::STAT_ACCEPTED) |-> m_axis_tdata_o[103])
    else $error("accepted sample reported without data_valid");

  a_valid_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && f_read_ok && !sample_bad |=> run_q == '0)
    else $error("valid sample did not clear the invalid run");

  a_pending_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && f_read_ok && !sample_bad && (f_raw == accepted_q) |=> pend_cnt_q == 2'd0)
    else $error("pending count kept while sample matches accepted word");
`endif

endmodule

`default_nettype wire
